>>> hw/rtl/rqs_pkg.sv
package rqs_pkg;

	localparam int unsigned TAG_W = 6;

	typedef struct packed {
		logic signed [15:0] key;
		logic [TAG_W-1:0]   tag;
		logic               last_item;
	} rqs_in_t;

	typedef struct packed {
		logic signed [15:0] sorted_key;
		logic [TAG_W-1:0]   sorted_tag;
		logic               last_out;
	} rqs_out_t;

endpackage

>>> hw/rtl/record_quicksort_by_key_core.sv
// Record sorter: collects keyed records and returns them in ascending key order.
// Input channel (in_valid/in_ready, payload in_data) takes one record per cycle
// while loading. A record with last_item set, or the record that fills the store,
// ends the set. The block then runs a Lomuto quicksort over its record memory
// with an explicit range stack; a key equal to the pivot's stays above it.
// The sort walks the record memory through a single compare unit, one read per
// cycle; a compare that swaps also reads element b and writes both back.
// Each range adds a pop, a pivot fetch, a pivot swap and a push. The worst case
// is a set that arrives already sorted.
// The records then leave over the output channel (out_valid/out_ready, payload
// out_data), one per transfer, each only after the previous one has been taken,
// with last_out set on the final one. The output stage is a register; a stall by
// the receiver simply holds it, and the block takes no input until the whole run
// has been transferred.
// Reset clears the count, the stack pointer and the sequencer; the memories are
// not cleared, and only written entries are ever used.
module record_quicksort_by_key_core
	import rqs_pkg::*;
#(
	parameter int MAX_RECORDS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rqs_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output rqs_out_t out_data
);

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = AW + 1;
	localparam int RW = 16 + TAG_W;

	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_POP   = 4'd1;
	localparam logic [3:0] S_PIV   = 4'd2;
	localparam logic [3:0] S_RDJ   = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_SWB   = 4'd5;
	localparam logic [3:0] S_FIN   = 4'd6;
	localparam logic [3:0] S_FIN2  = 4'd7;
	localparam logic [3:0] S_PUSH  = 4'd8;
	localparam logic [3:0] S_ORD   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;
	localparam logic [3:0] S_POPRD = 4'd11;
	localparam logic [3:0] S_NXT   = 4'd12;

	logic [RW-1:0]   mem [MAX_RECORDS];
	logic [2*AW-1:0] stk [MAX_RECORDS];

	logic [3:0]    state_q;
	logic [CW-1:0] count_q, sp_q;
	logic [AW-1:0] lo_q, hi_q, j_q, b_q, rd_q;
	logic [RW-1:0] piv_q, rj_q, rb_q;
	logic [2*AW-1:0] top_q;
	logic          push2_q;
	rqs_out_t      out_q;
	logic          ov_q;

	wire [CW-1:0] lo_x = {1'b0, lo_q};
	wire [CW-1:0] hi_x = {1'b0, hi_q};
	wire [CW-1:0] b_x  = {1'b0, b_q};
	wire need_hi = (b_x + 1'b1) < hi_x;
	wire need_lo = b_x > (lo_x + 1'b1);
	wire less = $signed(rj_q[RW-1:TAG_W]) < $signed(piv_q[RW-1:TAG_W]);

	assign in_ready = (state_q == S_LOAD);
	assign out_valid = ov_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		rj_q <= mem[rd_q];
		top_q <= stk[sp_q[AW-1:0] - 1'b1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			sp_q <= '0;
			ov_q <= 1'b0;
			rd_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						mem[count_q[AW-1:0]] <= {in_data.key, in_data.tag};
						count_q <= count_q + 1'b1;
						if (in_data.last_item || count_q + 1'b1 == CW'(MAX_RECORDS)) begin
							if (count_q == '0) begin
								state_q <= S_ORD;
								rd_q <= '0;
							end else begin
								stk[0] <= {AW'(0), count_q[AW-1:0]};
								sp_q <= CW'(1);
								state_q <= S_POPRD;
							end
						end
					end
				end
				S_POPRD: state_q <= S_POP;
				S_POP: begin
					// pop a range and fetch its pivot
					if (sp_q == '0) begin
						state_q <= S_ORD;
						rd_q <= '0;
					end else begin
						lo_q <= top_q[2*AW-1:AW];
						hi_q <= top_q[AW-1:0];
						j_q <= top_q[2*AW-1:AW];
						b_q <= top_q[2*AW-1:AW];
						sp_q <= sp_q - 1'b1;
						rd_q <= top_q[AW-1:0];
						state_q <= S_PIV;
					end
				end
				S_PIV: begin
					rd_q <= j_q;
					state_q <= S_RDJ;
				end
				S_RDJ: begin
					piv_q <= rj_q;
					rd_q <= j_q;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// rj_q holds element j; read element b for a swap
					if (j_q == hi_q) begin
						rd_q <= b_q;
						state_q <= S_FIN;
					end else if (less) begin
						rb_q <= rj_q;
						rd_q <= b_q;
						state_q <= S_SWB;
					end else begin
						j_q <= j_q + 1'b1;
						rd_q <= j_q + 1'b1;
						state_q <= S_NXT;
					end
				end
				// wait for the read of the next element j
				S_NXT: state_q <= S_CMP;
				S_SWB: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					// rj_q now holds element b, rb_q the record bound for b
					mem[b_q] <= rb_q;
					mem[j_q] <= rj_q;
					if (j_q == hi_q) begin
						state_q <= S_PUSH;
						push2_q <= 1'b0;
					end else begin
						b_q <= b_q + 1'b1;
						j_q <= j_q + 1'b1;
						rd_q <= j_q + 1'b1;
						state_q <= S_NXT;
					end
				end
				S_FIN: begin
					rb_q <= piv_q;
					state_q <= S_FIN2;
				end
				S_PUSH: begin
					if (!push2_q) begin
						push2_q <= 1'b1;
						if (need_hi && sp_q < CW'(MAX_RECORDS)) begin
							stk[sp_q[AW-1:0]] <= {b_q + 1'b1, hi_q};
							sp_q <= sp_q + 1'b1;
						end
					end else begin
						if (need_lo && sp_q < CW'(MAX_RECORDS)) begin
							stk[sp_q[AW-1:0]] <= {lo_q, b_q - 1'b1};
							sp_q <= sp_q + 1'b1;
						end
						state_q <= S_POPRD;
					end
				end
				S_ORD: begin
					if (!ov_q || out_ready) begin
						if (ov_q && out_q.last_out) begin
							ov_q <= 1'b0;
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							ov_q <= 1'b0;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					out_q.sorted_key <= rj_q[RW-1:TAG_W];
					out_q.sorted_tag <= rj_q[TAG_W-1:0];
					out_q.last_out <= ({1'b0, rd_q} + 1'b1 == count_q);
					ov_q <= 1'b1;
					rd_q <= rd_q + 1'b1;
					state_q <= S_ORD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

>>> hw/rtl/rqs_checker.sv
module rqs_checker
	import rqs_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input rqs_out_t out_data
);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("load during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_out |=> !out_valid) else $error("extra output");

endmodule

bind record_quicksort_by_key_core rqs_checker u_rqs_checker (.*);
